// File: sv/assert_macros.svh
// Assertion macros used by the RTL file of the straight drive unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sdps_pkg.sv
// Types and constants of the straight drive PD sync unit.
`timescale 1ns / 1ps

package sdps_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 19;
   localparam int TARGET_W    = 19;
   localparam int BASE_W      = 7;
   localparam int GAIN_W      = 16;
   localparam int TIME_W      = 16;
   localparam int POWER_W     = 8;

   typedef logic signed [POWER_W-1:0] power_type;

   localparam power_type POWER_MAX   = 8'sd127;
   localparam power_type BRAKE_POWER = 8'sd30;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_TICKS = 3'd0,
      CSR_REVERSE_DIR  = 3'd1,
      CSR_BASE_POWER   = 3'd2,
      CSR_PROP_GAIN    = 3'd3,
      CSR_DERIV_GAIN   = 3'd4,
      CSR_MAX_TIME_MS  = 3'd5,
      CSR_HOLD_MODE    = 3'd6
   } csr_index_type;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 19'd0;
   localparam logic [BASE_W-1:0]   BASE_RESET   = 7'd100;
   localparam logic [GAIN_W-1:0]   PROP_RESET   = 16'd102;
   localparam logic [GAIN_W-1:0]   DERIV_RESET  = 16'd0;
   localparam logic [TIME_W-1:0]   TIME_RESET   = 16'd1500;

endpackage

// File: sv/straight_drive_pd_sync_unit.sv
// Straight drive PD sync unit: encoder error, PD correction and brake/finish control.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | restart, left_count, right_count, elapsed_ms
//   rsp     | out       | rsp_valid/stall   | left_power, right_power, done_res
//   csr     | in        | csr_wr_en         | csr_index, csr_wdata
//
// While rsp is not stalled, one transfer per cycle is taken on req and one result
// per cycle leaves on rsp. An item passes three register stages: the input register,
// the product register that follows the two gain multipliers, and the result register
// that drives rsp. Reset is synchronous and active high; it loads the register
// defaults and clears the run state. A stall on rsp holds each full stage that has no
// empty stage after it, and backs up to req_stall.
`timescale 1ns / 1ps

module straight_drive_pd_sync_unit #(
   parameter int COUNT_WIDTH    = 20,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   input  logic signed [COUNT_WIDTH-1:0]        req_left_count,
   input  logic signed [COUNT_WIDTH-1:0]        req_right_count,
   input  logic [sdps_pkg::TIME_W-1:0]          req_elapsed_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sdps_pkg::power_type                  rsp_left_power,
   output sdps_pkg::power_type                  rsp_right_power,
   output logic                                 rsp_done_res,
   input  logic                                 csr_wr_en,
   input  logic [sdps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sdps_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sdps_pkg::*;

`include "assert_macros.svh"

   localparam int CW     = COUNT_WIDTH;
   localparam int FB     = GAIN_FRAC_BITS;
   localparam int ERR_W  = CW + 1;
   localparam int DER_W  = CW + 2;
   localparam int PP_W   = ERR_W + GAIN_W + 1;
   localparam int PD_W   = DER_W + GAIN_W + 1;
   localparam int CMP_W  = (CW > TARGET_W) ? CW : TARGET_W;
   localparam int SUM_W  = (((PD_W + 1) > (FB + BASE_W + 1)) ? (PD_W + 1)
                                                             : (FB + BASE_W + 1)) + 1;
   localparam logic signed [SUM_W-1:0] Q_LIM = SUM_W'(POWER_MAX) <<< FB;

   // Configuration registers.
   logic [TARGET_W-1:0] target_ff;
   logic                reverse_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [GAIN_W-1:0]   prop_ff;
   logic [GAIN_W-1:0]   deriv_ff;
   logic [TIME_W-1:0]   max_time_ff;
   logic                hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         reverse_ff  <= 1'b0;
         base_ff     <= BASE_RESET;
         prop_ff     <= PROP_RESET;
         deriv_ff    <= DERIV_RESET;
         max_time_ff <= TIME_RESET;
         hold_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET_TICKS: target_ff   <= csr_wdata[TARGET_W-1:0];
            CSR_REVERSE_DIR:  reverse_ff  <= csr_wdata[0];
            CSR_BASE_POWER:   base_ff     <= csr_wdata[BASE_W-1:0];
            CSR_PROP_GAIN:    prop_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:   deriv_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_MAX_TIME_MS:  max_time_ff <= csr_wdata[TIME_W-1:0];
            CSR_HOLD_MODE:    hold_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control: a stage moves on when the one after it is free.
   logic a_vld_ff, b_vld_ff, c_vld_ff;
   logic c_free, b_free, a_free, a_move, b_move, req_take;

   assign c_free   = !c_vld_ff || !rsp_stall;
   assign b_free   = !b_vld_ff || c_free;
   assign b_move   = b_vld_ff && c_free;
   assign a_free   = !a_vld_ff || b_free;
   assign a_move   = a_vld_ff && b_free;
   assign req_stall = !a_free;
   assign req_take = req_valid && a_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_vld_ff <= req_valid;
         end
         if (b_free) begin
            b_vld_ff <= a_move;
         end
         if (c_free) begin
            c_vld_ff <= b_move;
         end
      end
   end

   // Input register.
   logic                   a_restart_ff;
   logic signed [CW-1:0]   a_left_ff;
   logic signed [CW-1:0]   a_right_ff;
   logic [TIME_W-1:0]      a_elapsed_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_restart_ff <= req_restart;
         a_left_ff    <= req_left_count;
         a_right_ff   <= req_right_count;
         a_elapsed_ff <= req_elapsed_ms;
      end
   end

   // Run state, updated as an item leaves the input register.
   logic signed [ERR_W-1:0] last_error_ff, last_error_in;
   logic                    passed_ff, passed_in;
   logic                    finished_ff, finished_in;

   logic signed [ERR_W-1:0] prev_err;
   logic                    prev_passed, prev_finished, finish_now;
   logic [CW-1:0]           left_mag, right_mag;
   logic signed [ERR_W-1:0] err;
   logic signed [DER_W-1:0] deriv;
   logic signed [GAIN_W:0]  prop_s, deriv_s;
   logic signed [PP_W-1:0]  prod_p;
   logic signed [PD_W-1:0]  prod_d;

   always_comb begin
      // A restart clears the run state before this tick is judged.
      prev_err      = a_restart_ff ? '0 : last_error_ff;
      prev_passed   = a_restart_ff ? 1'b0 : passed_ff;
      prev_finished = a_restart_ff ? 1'b0 : finished_ff;
      finish_now    = prev_finished || prev_passed || (a_elapsed_ff > max_time_ff);

      left_mag  = a_left_ff[CW-1]  ? CW'(~a_left_ff + 1'b1)  : CW'(a_left_ff);
      right_mag = a_right_ff[CW-1] ? CW'(~a_right_ff + 1'b1) : CW'(a_right_ff);
      err = reverse_ff ? ($signed({1'b0, right_mag}) - $signed({1'b0, left_mag}))
                       : ($signed({1'b0, left_mag}) - $signed({1'b0, right_mag}));
      deriv = DER_W'(err) - DER_W'(prev_err);

      prop_s  = $signed({1'b0, prop_ff});
      deriv_s = $signed({1'b0, deriv_ff});
      prod_p  = PP_W'(err) * PP_W'(prop_s);
      prod_d  = PD_W'(deriv) * PD_W'(deriv_s);

      finished_in   = finish_now;
      last_error_in = finish_now ? prev_err : err;
      passed_in     = finish_now ? prev_passed
                                 : (CMP_W'(left_mag) > CMP_W'(target_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         passed_ff     <= 1'b0;
         finished_ff   <= 1'b0;
      end else if (a_move) begin
         last_error_ff <= last_error_in;
         passed_ff     <= passed_in;
         finished_ff   <= finished_in;
      end
   end

   // Product register.
   logic signed [PP_W-1:0] b_prod_p_ff;
   logic signed [PD_W-1:0] b_prod_d_ff;
   logic                   b_finish_ff;

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_prod_p_ff <= prod_p;
         b_prod_d_ff <= prod_d;
         b_finish_ff <= finish_now;
      end
   end

   // Follower power: base plus correction (base minus correction in reverse), clamped and truncated toward zero.
   logic signed [SUM_W-1:0] corr, base_q, follow_q, floor_q;
   logic                    round_up;
   power_type               follow_pow, lead_pow, brake_pow;
   power_type               left_in, right_in;

   always_comb begin
      corr     = SUM_W'(b_prod_p_ff) + SUM_W'(b_prod_d_ff);
      base_q   = SUM_W'($signed({1'b0, base_ff, {FB{1'b0}}}));
      // In reverse the follower is the left side, and its value is negated by direction.
      follow_q = reverse_ff ? (corr - base_q) : (corr + base_q);
      floor_q  = follow_q >>> FB;
      round_up = follow_q[SUM_W-1] && (|follow_q[FB-1:0]);

      priority if (follow_q > Q_LIM) begin
         follow_pow = POWER_MAX;
      end else if (follow_q < -Q_LIM) begin
         follow_pow = -POWER_MAX;
      end else begin
         follow_pow = POWER_W'(floor_q) + POWER_W'(round_up);
      end

      lead_pow  = reverse_ff ? -power_type'({1'b0, base_ff}) : power_type'({1'b0, base_ff});
      brake_pow = !hold_ff ? '0 : (reverse_ff ? BRAKE_POWER : -BRAKE_POWER);

      priority if (b_finish_ff) begin
         left_in  = brake_pow;
         right_in = brake_pow;
      end else if (reverse_ff) begin
         left_in  = follow_pow;
         right_in = lead_pow;
      end else begin
         left_in  = lead_pow;
         right_in = follow_pow;
      end
   end

   // Result register.
   power_type c_left_ff, c_right_ff;
   logic      c_done_ff;

   always_ff @(posedge clock) begin
      if (b_move) begin
         c_left_ff  <= left_in;
         c_right_ff <= right_in;
         c_done_ff  <= b_finish_ff;
      end
   end

   assign rsp_valid       = c_vld_ff;
   assign rsp_left_power  = c_left_ff;
   assign rsp_right_power = c_right_ff;
   assign rsp_done_res    = c_done_ff;

   `ASSERT_CLK(a_brake_equal, clock, reset, rsp_valid && rsp_done_res |-> rsp_left_power == rsp_right_power, "brake powers differ")
   `ASSERT_CLK(a_power_range, clock, reset, rsp_valid |-> rsp_left_power != -8'sd128 && rsp_right_power != -8'sd128, "power out of range")
   `ASSERT_CLK(a_finish_sticks, clock, reset, a_move && !a_restart_ff && finished_ff |=> finished_ff, "finished cleared without restart")
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

// File: verif/straight_drive_pd_sync_unit_checker.sv
// Drive command checker: predicts each motor command and compares it with the block's output.
`timescale 1ns / 1ps

module straight_drive_pd_sync_unit_checker #(
   parameter int COUNT_WIDTH    = 20,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_restart,
   input  logic signed [COUNT_WIDTH-1:0]     req_left_count,
   input  logic signed [COUNT_WIDTH-1:0]     req_right_count,
   input  logic [sdps_pkg::TIME_W-1:0]       req_elapsed_ms,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  sdps_pkg::power_type               rsp_left_power,
   input  sdps_pkg::power_type               rsp_right_power,
   input  logic                              rsp_done_res,
   input  logic                              csr_wr_en,
   input  logic [sdps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sdps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                mismatch_count,
   output int                                pending_cmds,
   output int                                checked_cmds,
   output int                                brake_cmds
);
   import sdps_pkg::*;

   typedef struct {
      power_type left;
      power_type right;
      logic      done;
   } drive_cmd_type;

   drive_cmd_type cmd_queue[$];

   // Shadow copy of the registers.
   logic [TARGET_W-1:0] target_ticks;
   logic                reverse_dir;
   logic [BASE_W-1:0]   base_power;
   logic [GAIN_W-1:0]   prop_gain;
   logic [GAIN_W-1:0]   deriv_gain;
   logic [TIME_W-1:0]   max_time_ms;
   logic                hold_mode;

   // Run state.
   longint last_error;
   bit     target_passed;
   bit     run_finished;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // Clamp a fixed-point power to the motor range, then truncate toward zero.
   function automatic power_type clamp_power(input longint q);
      longint lim;
      lim = longint'(POWER_MAX) << GAIN_FRAC_BITS;
      if (q > lim) return POWER_MAX;
      if (q < -lim) return power_type'(-longint'(POWER_MAX));
      return power_type'(q / (longint'(1) << GAIN_FRAC_BITS));
   endfunction

   function automatic drive_cmd_type drive_step(input logic restart,
                                                input logic signed [COUNT_WIDTH-1:0] left,
                                                input logic signed [COUNT_WIDTH-1:0] right,
                                                input logic [TIME_W-1:0] elapsed);
      longint dir, lval, rval, lmag, rmag, err, corr, baseq, lq, rq, brake;
      drive_cmd_type cmd;
      dir = reverse_dir ? -1 : 1;
      lval = longint'(left);
      rval = longint'(right);
      if (restart) begin
         last_error = 0;
         target_passed = 1'b0;
         run_finished = 1'b0;
      end
      if (run_finished || target_passed || elapsed > max_time_ms) begin
         brake = hold_mode ? -longint'(BRAKE_POWER) * dir : 0;
         run_finished = 1'b1;
         cmd.left = power_type'(brake);
         cmd.right = power_type'(brake);
         cmd.done = 1'b1;
         return cmd;
      end
      lmag = (lval < 0) ? -lval : lval;
      rmag = (rval < 0) ? -rval : rval;
      // The leading side is left going forward and right going backward.
      err = reverse_dir ? (rmag - lmag) : (lmag - rmag);
      corr = err * longint'(prop_gain) + (err - last_error) * longint'(deriv_gain);
      baseq = longint'(base_power) << GAIN_FRAC_BITS;
      if (reverse_dir) begin
         rq = baseq;
         lq = baseq - corr;
      end else begin
         lq = baseq;
         rq = baseq + corr;
      end
      cmd.left = clamp_power(lq * dir);
      cmd.right = clamp_power(rq * dir);
      cmd.done = 1'b0;
      last_error = err;
      target_passed = lmag > longint'(target_ticks);
      return cmd;
   endfunction

   always @(posedge clock) begin
      drive_cmd_type want;
      if (reset) begin
         target_ticks = TARGET_RESET;
         reverse_dir = 1'b0;
         base_power = BASE_RESET;
         prop_gain = PROP_RESET;
         deriv_gain = DERIV_RESET;
         max_time_ms = TIME_RESET;
         hold_mode = 1'b0;
         last_error = 0;
         target_passed = 1'b0;
         run_finished = 1'b0;
         cmd_queue.delete();
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_TARGET_TICKS: target_ticks = csr_wdata[TARGET_W-1:0];
               CSR_REVERSE_DIR:  reverse_dir = csr_wdata[0];
               CSR_BASE_POWER:   base_power = csr_wdata[BASE_W-1:0];
               CSR_PROP_GAIN:    prop_gain = csr_wdata[GAIN_W-1:0];
               CSR_DERIV_GAIN:   deriv_gain = csr_wdata[GAIN_W-1:0];
               CSR_MAX_TIME_MS:  max_time_ms = csr_wdata[TIME_W-1:0];
               CSR_HOLD_MODE:    hold_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            cmd_queue.push_back(drive_step(req_restart, req_left_count, req_right_count,
                                           req_elapsed_ms));
         if (rsp_valid && !rsp_stall) begin
            if (cmd_queue.size() == 0) begin
               report_mismatch("result transfer with no command expected");
            end else begin
               want = cmd_queue.pop_front();
               checked_cmds++;
               if (want.done) brake_cmds++;
               if (rsp_left_power !== want.left)
                  report_mismatch($sformatf("left_power got %0d expected %0d",
                                            rsp_left_power, want.left));
               if (rsp_right_power !== want.right)
                  report_mismatch($sformatf("right_power got %0d expected %0d",
                                            rsp_right_power, want.right));
               if (rsp_done_res !== want.done)
                  report_mismatch($sformatf("done_res got %b expected %b",
                                            rsp_done_res, want.done));
            end
         end
      end
      pending_cmds = cmd_queue.size();
   end

endmodule

// File: verif/straight_drive_pd_sync_unit_test.sv
// Top of the straight drive unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module straight_drive_pd_sync_unit_test;
   import sdps_pkg::*;

   localparam int COUNT_W = 20;
   localparam int PHASE_TICKS = 120;

   typedef logic signed [COUNT_W-1:0] count_type;
   typedef logic [TIME_W-1:0] ms_type;

   typedef struct {
      logic [TARGET_W-1:0] target;
      logic                rev;
      logic [BASE_W-1:0]   base;
      logic [GAIN_W-1:0]   kp;
      logic [GAIN_W-1:0]   kd;
      logic [TIME_W-1:0]   tmax;
      logic                hold;
   } drive_setup_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_restart;
   count_type              req_left_count;
   count_type              req_right_count;
   ms_type                 req_elapsed_ms;
   logic                   rsp_valid;
   logic                   rsp_stall;
   power_type              rsp_left_power;
   power_type              rsp_right_power;
   logic                   rsp_done_res;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int pending_cmds;
   int checked_cmds;
   int brake_cmds;
   int send_idle_pct;
   int stall_pct;
   int hold_request;
   int hold_left;
   int ticks_sent;
   int setups_loaded;

   straight_drive_pd_sync_unit #(
      .COUNT_WIDTH(COUNT_W),
      .GAIN_FRAC_BITS(12)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .req_left_count(req_left_count),
      .req_right_count(req_right_count),
      .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_power(rsp_left_power),
      .rsp_right_power(rsp_right_power),
      .rsp_done_res(rsp_done_res),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   straight_drive_pd_sync_unit_checker #(
      .COUNT_WIDTH(COUNT_W),
      .GAIN_FRAC_BITS(12)
   ) power_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .req_left_count(req_left_count),
      .req_right_count(req_right_count),
      .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_power(rsp_left_power),
      .rsp_right_power(rsp_right_power),
      .rsp_done_res(rsp_done_res),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .pending_cmds(pending_cmds),
      .checked_cmds(checked_cmds),
      .brake_cmds(brake_cmds)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = 80;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Holds the tick until the block takes it; returns at the next falling edge.
   task automatic send_tick(input int rs, input int l, input int r, input int ms);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_restart <= rs[0];
      req_left_count <= count_type'(l);
      req_right_count <= count_type'(r);
      req_elapsed_ms <= ms_type'(ms);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_cmds != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
   endtask

   task automatic load_setup(input drive_setup_type s);
      write_reg(CSR_TARGET_TICKS, CSR_DATA_W'(s.target));
      write_reg(CSR_REVERSE_DIR, CSR_DATA_W'(s.rev));
      write_reg(CSR_BASE_POWER, CSR_DATA_W'(s.base));
      write_reg(CSR_PROP_GAIN, CSR_DATA_W'(s.kp));
      write_reg(CSR_DERIV_GAIN, CSR_DATA_W'(s.kd));
      write_reg(CSR_MAX_TIME_MS, CSR_DATA_W'(s.tmax));
      write_reg(CSR_HOLD_MODE, CSR_DATA_W'(s.hold));
      csr_wr_en <= 1'b0;
      setups_loaded++;
   endtask

   // Flavors: all low with a random direction, all high, realistic, and fully random bits.
   function automatic drive_setup_type pick_setup(input int flavor);
      drive_setup_type s;
      unique case (flavor)
         0: s = '{target: '0, rev: 1'($urandom_range(1)), base: '0, kp: '0, kd: '0,
                  tmax: '0, hold: 1'b0};
         1: s = '{target: '1, rev: 1'b1, base: '1, kp: '1, kd: '1, tmax: '1, hold: 1'b1};
         2: begin
            s.target = TARGET_W'($urandom_range(0, 4000));
            s.rev = 1'($urandom_range(1));
            s.base = BASE_W'($urandom_range(0, 127));
            s.kp = GAIN_W'($urandom_range(0, 2000));
            s.kd = GAIN_W'($urandom_range(0, 3000));
            s.tmax = TIME_W'($urandom_range(100, 2500));
            s.hold = 1'($urandom_range(1));
         end
         default: begin
            s.target = TARGET_W'($urandom);
            s.rev = 1'($urandom);
            s.base = BASE_W'($urandom);
            s.kp = GAIN_W'($urandom);
            s.kd = GAIN_W'($urandom);
            s.tmax = TIME_W'($urandom);
            s.hold = 1'($urandom);
         end
      endcase
      return s;
   endfunction

   // One run: a restart, then wheel counts that grow at slightly different rates.
   task automatic run_drive(input int n_ticks);
      longint lmag, rmag, ms;
      int lsign, rsign;
      lsign = ($urandom_range(1) != 0) ? -1 : 1;
      rsign = ($urandom_range(1) != 0) ? -1 : 1;
      lmag = longint'($urandom_range(0, 20));
      rmag = longint'($urandom_range(0, 20));
      ms = longint'($urandom_range(0, 30));
      send_tick(1, int'(lsign * lmag), int'(rsign * rmag), int'(ms));
      for (int i = 0; i < n_ticks; i++) begin
         int stepv;
         int jitter;
         stepv = int'($urandom_range(0, 150));
         jitter = int'($urandom_range(0, 40));
         jitter = jitter - 20;
         lmag += stepv;
         rmag += stepv + jitter;
         if (rmag < 0) rmag = 0;
         if (lmag > 524287) lmag = 524287;
         if (rmag > 524287) rmag = 524287;
         ms += longint'($urandom_range(0, 50));
         if (ms > 65535) ms = 65535;
         send_tick(0, int'(lsign * lmag), int'(rsign * rmag), int'(ms));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_restart = 1'b0;
      req_left_count = '0;
      req_right_count = '0;
      req_elapsed_ms = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 12;
      stall_pct = 81;
      hold_request = 0;
      ticks_sent = 0;
      setups_loaded = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Register defaults after reset: forward, target zero, no hold.
      send_tick(1, 0, 0, 0);
      send_tick(0, -200, 150, 25);
      send_tick(0, -400, 300, 50);
      send_tick(1, -524288, 524287, 1500);
      send_tick(1, 524287, -524288, 1501);
      send_tick(0, 5, 5, 0);

      // Everything at its top value; the correction saturates the follower motor.
      wait_drained();
      load_setup(pick_setup(1));
      send_tick(1, 0, 0, 0);
      send_tick(0, 1000, -524288, 100);
      send_tick(0, -524288, 0, 65535);
      send_tick(0, 0, 0, 0);
      send_tick(1, 524287, 524287, 65535);
      send_tick(1, -1, 1, 0);

      // Derivative term only, zero timeout, hold brake going forward.
      wait_drained();
      load_setup('{target: TARGET_W'(100), rev: 1'b0, base: '0, kp: '0, kd: GAIN_W'(4096),
                   tmax: '0, hold: 1'b1});
      send_tick(1, -50, 60, 0);
      send_tick(0, -100, 90, 0);
      send_tick(0, 0, 0, 1);
      send_tick(1, 101, 0, 0);
      send_tick(0, 0, 0, 0);

      // Tiny gain in reverse, so negative fractions must truncate toward zero.
      wait_drained();
      load_setup('{target: '1, rev: 1'b1, base: BASE_W'(10), kp: GAIN_W'(1), kd: '0,
                   tmax: '1, hold: 1'b0});
      send_tick(1, -3, 2, 0);
      send_tick(0, 2, 3, 5);
      send_tick(1, 0, 0, 0);

      for (int p = 0; p < 12; p++) begin
         int phase_start;
         wait_drained();
         unique case (p / 4)
            0: begin
               send_idle_pct = 12;
               stall_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               stall_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
         endcase
         load_setup(pick_setup(p % 4));
         // The sender keeps going while the result side holds off, so the pipe backs up.
         if (p == 8) hold_request = 1;
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < PHASE_TICKS) begin
            if ($urandom_range(9) == 0)
               send_tick(int'($urandom_range(1)), int'($urandom), int'($urandom),
                         int'($urandom));
            else
               run_drive(int'($urandom_range(5, 45)));
         end
      end

      wait_drained();
      repeat (10) @(negedge clock);
      $display("summary: %0d control ticks under %0d register settings, %0d commands checked",
               ticks_sent, setups_loaded + 1, checked_cmds);
      $display("summary: %0d of them were brake commands, %0d mismatches",
               brake_cmds, mismatch_count);
      if (mismatch_count == 0 && pending_cmds == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/sdps_pkg.sv
sv/straight_drive_pd_sync_unit.sv
verif/straight_drive_pd_sync_unit_checker.sv
verif/straight_drive_pd_sync_unit_test.sv
